// ----- sv/fcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared widths, constants and types of the filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

    localparam int COORD_W    = 16;
    localparam int SPAN_W     = 17;
    localparam int RADIUS_W   = 10;
    localparam int STEP_W     = 11;
    localparam int DECISION_W = 16;
    localparam int COLOR_W    = 32;

    localparam int MAX_RADIUS = 1023;

    localparam logic ACTION_START   = 1'b0;
    localparam logic ACTION_ADVANCE = 1'b1;

    // Running walk state of the circle being filled
    typedef struct packed {
        logic signed [COORD_W-1:0]    center_x;
        logic signed [COORD_W-1:0]    center_y;
        logic [STEP_W-1:0]            step_x;
        logic [STEP_W-1:0]            step_y;
        logic signed [DECISION_W-1:0] decision;
        logic [COLOR_W-1:0]           color;
        logic                         busy;
    } circle_state_t;

    // Precomputed endpoints of one group of four spans
    typedef struct packed {
        logic signed [SPAN_W-1:0] cx_minus_x;
        logic signed [SPAN_W-1:0] cx_plus_x;
        logic signed [SPAN_W-1:0] cx_minus_y;
        logic signed [SPAN_W-1:0] cx_plus_y;
        logic signed [SPAN_W-1:0] cy_minus_y;
        logic signed [SPAN_W-1:0] cy_minus_x;
        logic signed [SPAN_W-1:0] cy_plus_y;
        logic signed [SPAN_W-1:0] cy_plus_x;
        logic [COLOR_W-1:0]       color;
        logic                     done;
    } span_group_t;

endpackage

// ----- sv/fcsg_step_calc.sv -----
// ----------------------------------------------------------------------------
// fcsg_step_calc
// One midpoint step: picks the walk state (fresh start or held), forms the
// four span endpoints and the updated decision, x, y and busy.
// ----------------------------------------------------------------------------
module fcsg_step_calc (
    input  logic                                  action,
    input  logic signed [fcsg_pkg::COORD_W-1:0]   center_x,
    input  logic signed [fcsg_pkg::COORD_W-1:0]   center_y,
    input  logic [fcsg_pkg::RADIUS_W-1:0]         radius,
    input  logic [fcsg_pkg::COLOR_W-1:0]          fill_color,
    input  fcsg_pkg::circle_state_t               state_cur,
    output fcsg_pkg::circle_state_t               state_next,
    output fcsg_pkg::span_group_t                 group,
    output logic                                  emit
);

    logic [fcsg_pkg::RADIUS_W-1:0]           radius_sat;
    fcsg_pkg::circle_state_t                 src;
    logic signed [fcsg_pkg::SPAN_W-1:0]      cx_ext;
    logic signed [fcsg_pkg::SPAN_W-1:0]      cy_ext;
    logic signed [fcsg_pkg::SPAN_W-1:0]      x_ext;
    logic signed [fcsg_pkg::SPAN_W-1:0]      y_ext;
    logic [fcsg_pkg::STEP_W:0]               diff_xy;
    logic signed [fcsg_pkg::DECISION_W-1:0]  inc_diag;
    logic signed [fcsg_pkg::DECISION_W-1:0]  inc_horz;
    logic [fcsg_pkg::STEP_W-1:0]             x_new;
    logic [fcsg_pkg::STEP_W-1:0]             y_new;

    always_comb begin
        // saturate the radius
        if (radius > fcsg_pkg::RADIUS_W'(fcsg_pkg::MAX_RADIUS)) begin
            radius_sat = fcsg_pkg::RADIUS_W'(fcsg_pkg::MAX_RADIUS);
        end else begin
            radius_sat = radius;
        end

        // select the walk state this request works from
        src = state_cur;
        if (action == fcsg_pkg::ACTION_START) begin
            src.center_x = center_x;
            src.center_y = center_y;
            src.color    = fill_color;
            src.step_x   = '0;
            src.step_y   = fcsg_pkg::STEP_W'(radius_sat);
            src.decision = fcsg_pkg::DECISION_W'(3)
                         - fcsg_pkg::DECISION_W'({radius_sat, 1'b0});
            src.busy     = (radius_sat != '0);
        end

        emit = src.busy;

        // span endpoints from the pre-update x and y
        cx_ext = {src.center_x[fcsg_pkg::COORD_W-1], src.center_x};
        cy_ext = {src.center_y[fcsg_pkg::COORD_W-1], src.center_y};
        x_ext  = $signed(fcsg_pkg::SPAN_W'(src.step_x));
        y_ext  = $signed(fcsg_pkg::SPAN_W'(src.step_y));

        group.cx_minus_x = cx_ext - x_ext;
        group.cx_plus_x  = cx_ext + x_ext;
        group.cx_minus_y = cx_ext - y_ext;
        group.cx_plus_y  = cx_ext + y_ext;
        group.cy_minus_y = cy_ext - y_ext;
        group.cy_minus_x = cy_ext - x_ext;
        group.cy_plus_y  = cy_ext + y_ext;
        group.cy_plus_x  = cy_ext + x_ext;
        group.color      = src.color;

        // decision update
        diff_xy  = {1'b0, src.step_x} - {1'b0, src.step_y};
        inc_diag = $signed(fcsg_pkg::DECISION_W'({{(fcsg_pkg::DECISION_W
                   - fcsg_pkg::STEP_W - 3){diff_xy[fcsg_pkg::STEP_W]}},
                   diff_xy, 2'b00})) + fcsg_pkg::DECISION_W'(10);
        inc_horz = $signed(fcsg_pkg::DECISION_W'({src.step_x, 2'b00}))
                 + fcsg_pkg::DECISION_W'(6);

        x_new = src.step_x + 1'b1;
        state_next = src;
        state_next.step_x = x_new;
        if (src.decision < 0) begin
            y_new               = src.step_y;
            state_next.decision = src.decision + inc_horz;
        end else begin
            y_new               = src.step_y - 1'b1;
            state_next.decision = src.decision + inc_diag;
        end
        state_next.step_y = y_new;
        group.done        = (y_new < x_new);
        state_next.busy   = !(y_new < x_new);

        // idle requests: zero radius start keeps loaded values, idle advance
        // changes nothing
        if (!emit) begin
            state_next = src;
        end
    end

endmodule

// ----- sv/filled_circle_span_generator_unit.sv -----
// ----------------------------------------------------------------------------
// filled_circle_span_generator_unit
// Midpoint circle fill: emits horizontal spans, four per producing step request.
// ----------------------------------------------------------------------------
// A start request (tuser = 0) loads center, radius and color and emits the
// first group of four spans; each advance request (tuser = 1) emits the next
// group. Spans come out in walk order with repeats and overlaps kept; the
// fourth span of a group carries tlast and every span of the final group
// carries m_tuser (circle done), after which the unit is idle. A start with
// zero radius or an advance while idle produces no spans. A producing request
// sends its four spans on the result channel, one span per cycle while
// m_tready is high, and the next request is taken in the cycle the fourth
// span leaves, so the single span output sets the pace of a steady stream.
// Requests that produce nothing are taken while the group buffer is empty.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // center_x[15:0], center_y[31:16],
                                   // radius[41:32], fill_color[73:42], zero pad
    input  logic        s_tuser,   // action: 0 start, 1 advance
    // span channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // span_x_start[16:0], span_x_end[33:17],
                                   // span_y[50:34], span_color[82:51], zero pad
    output logic        m_tlast,   // last_in_step
    output logic        m_tuser    // circle_done
);

    fcsg_pkg::circle_state_t state_reg;
    fcsg_pkg::circle_state_t state_next;
    fcsg_pkg::span_group_t   group_reg;
    fcsg_pkg::span_group_t   group_calc;
    logic                    group_valid_reg;
    logic [1:0]              span_idx_reg;
    logic                    emit;
    logic                    s_accept;
    logic                    m_accept;
    logic                    last_span;

    logic signed [fcsg_pkg::SPAN_W-1:0] out_xs;
    logic signed [fcsg_pkg::SPAN_W-1:0] out_xe;
    logic signed [fcsg_pkg::SPAN_W-1:0] out_y;

    // step arithmetic on the incoming request
    fcsg_step_calc u_step_calc (
        .action     (s_tuser),
        .center_x   (s_tdata[15:0]),
        .center_y   (s_tdata[31:16]),
        .radius     (s_tdata[41:32]),
        .fill_color (s_tdata[73:42]),
        .state_cur  (state_reg),
        .state_next (state_next),
        .group      (group_calc),
        .emit       (emit)
    );

    assign last_span = (span_idx_reg == 2'd3);
    assign m_accept  = m_tvalid && m_tready;
    // take a request when the group buffer is empty or its last span leaves
    assign s_tready  = !group_valid_reg || (m_tready && last_span);
    assign s_accept  = s_tvalid && s_tready;

    // walk state: advance on every accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // group buffer and span counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_valid_reg <= 1'b0;
            span_idx_reg    <= 2'd0;
        end else if (s_accept) begin
            group_valid_reg <= emit;
            span_idx_reg    <= 2'd0;
        end else if (m_accept) begin
            span_idx_reg <= span_idx_reg + 2'd1;
            if (last_span) begin
                group_valid_reg <= 1'b0;
            end
        end
    end

    // payload holds no reset
    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            group_reg <= group_calc;
        end
    end

    // pick the span of the group in walk order
    always_comb begin
        case (span_idx_reg)
            2'd0: begin
                out_xs = group_reg.cx_minus_x;
                out_xe = group_reg.cx_plus_x;
                out_y  = group_reg.cy_minus_y;
            end
            2'd1: begin
                out_xs = group_reg.cx_minus_y;
                out_xe = group_reg.cx_plus_y;
                out_y  = group_reg.cy_minus_x;
            end
            2'd2: begin
                out_xs = group_reg.cx_minus_x;
                out_xe = group_reg.cx_plus_x;
                out_y  = group_reg.cy_plus_y;
            end
            default: begin
                out_xs = group_reg.cx_minus_y;
                out_xe = group_reg.cx_plus_y;
                out_y  = group_reg.cy_plus_x;
            end
        endcase
    end

    assign m_tvalid = group_valid_reg;
    assign m_tdata  = {5'b0, group_reg.color, out_y, out_xe, out_xs};
    assign m_tlast  = last_span;
    assign m_tuser  = group_reg.done;

endmodule
